// ===== design/fbc_pkg.sv =====
// Shared types, constants and substitution tables for the 16-bit Feistel block.
// Used by the configuration registers, the round logic, the datapath and the top level.
`timescale 1ns / 1ps

package fbc_pkg;

    localparam int HALF_W         = 8;
    localparam int NIBBLE_W       = 4;
    localparam int ROUND_COUNT_W  = 4;
    localparam int NUM_KEYS       = 8;
    localparam int KEY_IDX_W      = 3;
    localparam int KEYS_W         = NUM_KEYS * HALF_W;
    localparam int CFG_INDEX_W    = 2;
    localparam int ROTATE_AMOUNT  = 3;
    localparam int DEF_MAX_ROUNDS = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROUND_COUNT = 2'd0,
        REG_ROUND_KEYS  = 2'd1
    } cfg_reg_t;

    // Direction of the transform.
    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } action_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [ROUND_COUNT_W-1:0] round_count;
        logic [KEYS_W-1:0]        round_keys;
    } cfg_t;

    // High nibble substitution: ((3^n mod 17) + 2) mod 16.
    function automatic logic [NIBBLE_W-1:0] hi_sub(input logic [NIBBLE_W-1:0] n);
        logic [NIBBLE_W-1:0] s;
        unique case (n)
            4'd0:  s = 4'd3;
            4'd1:  s = 4'd5;
            4'd2:  s = 4'd11;
            4'd3:  s = 4'd12;
            4'd4:  s = 4'd15;
            4'd5:  s = 4'd7;
            4'd6:  s = 4'd1;
            4'd7:  s = 4'd13;
            4'd8:  s = 4'd2;
            4'd9:  s = 4'd0;
            4'd10: s = 4'd10;
            4'd11: s = 4'd9;
            4'd12: s = 4'd6;
            4'd13: s = 4'd14;
            4'd14: s = 4'd4;
            4'd15: s = 4'd8;
        endcase
        return s;
    endfunction

    // Low nibble substitution: ((5^n mod 17) + 7) mod 16.
    function automatic logic [NIBBLE_W-1:0] lo_sub(input logic [NIBBLE_W-1:0] n);
        logic [NIBBLE_W-1:0] s;
        unique case (n)
            4'd0:  s = 4'd8;
            4'd1:  s = 4'd12;
            4'd2:  s = 4'd15;
            4'd3:  s = 4'd13;
            4'd4:  s = 4'd4;
            4'd5:  s = 4'd5;
            4'd6:  s = 4'd9;
            4'd7:  s = 4'd1;
            4'd8:  s = 4'd7;
            4'd9:  s = 4'd3;
            4'd10: s = 4'd0;
            4'd11: s = 4'd2;
            4'd12: s = 4'd11;
            4'd13: s = 4'd10;
            4'd14: s = 4'd6;
            4'd15: s = 4'd14;
        endcase
        return s;
    endfunction

endpackage

// ===== design/feistel_block_cipher_16bit.sv =====
// Top level of the 16-bit Feistel block: configuration registers and datapath.
// Depends on fbc_pkg, fbc_cfg_regs and fbc_datapath.
//
// Usage:
// The input channel (in_valid, in_stall) carries one word per block: the
// action (0 encrypt, 1 decrypt) and the two 8-bit halves left_in and
// right_in. The output channel (out_valid, out_stall) returns one word per
// block with left_out and right_out. A word moves at a rising edge where
// valid is high and stall is low.
// The block is captured in an input register, runs through all MAX_ROUNDS
// unrolled rounds as combinational logic, and lands in the result register.
// Throughput is one block per cycle while the receiver does not stall; the
// depth of the unrolled round chain sets the cycle time.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready. Index 0 writes the round count, index 1 the eight packed key
// bytes; other indexes are ignored. Write it only while no block is in flight.
// Reset clears both registers and empties the pipeline. When the receiver
// stalls, the result holds steady and one more block can still enter the
// input register before in_stall rises.
`timescale 1ns / 1ps

module feistel_block_cipher_16bit #(
    parameter int MAX_ROUNDS = fbc_pkg::DEF_MAX_ROUNDS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [fbc_pkg::HALF_W-1:0]         left_in,
    input  logic [fbc_pkg::HALF_W-1:0]         right_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fbc_pkg::HALF_W-1:0]         left_out,
    output logic [fbc_pkg::HALF_W-1:0]         right_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbc_pkg::KEYS_W-1:0]         cfg_data
);

    fbc_pkg::cfg_t cfg;

    // The register file has no busy state, so the port never waits.
    assign cfg_ready = 1'b1;

    fbc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The datapath holds one block in its input register and one result in
    // its output register, so the two sides of the handshake stay decoupled.
    fbc_datapath #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out)
    );

endmodule

// ===== design/fbc_cfg_regs.sv =====
// Configuration registers of the Feistel block: round count and packed round keys.
// Depends on fbc_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module fbc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [fbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fbc_pkg::KEYS_W-1:0]          cfg_data,
    output fbc_pkg::cfg_t                       cfg
);

    logic [fbc_pkg::ROUND_COUNT_W-1:0] round_count_reg;
    logic [fbc_pkg::KEYS_W-1:0]        round_keys_reg;

    // Writes to indexes outside the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= '0;
            round_keys_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (fbc_pkg::cfg_reg_t'(cfg_index))
                fbc_pkg::REG_ROUND_COUNT:
                    round_count_reg <= cfg_data[fbc_pkg::ROUND_COUNT_W-1:0];
                fbc_pkg::REG_ROUND_KEYS:
                    round_keys_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.round_count = round_count_reg;
    assign cfg.round_keys  = round_keys_reg;

endmodule

// ===== design/fbc_round.sv =====
// One Feistel round: key mix, nibble substitution, rotate and cross XOR.
// Depends on fbc_pkg for the substitution tables and the action codes.
`timescale 1ns / 1ps

module fbc_round (
    input  logic                          active,
    input  fbc_pkg::action_t              action,
    input  logic [fbc_pkg::HALF_W-1:0]    l_in,
    input  logic [fbc_pkg::HALF_W-1:0]    r_in,
    input  logic [fbc_pkg::HALF_W-1:0]    key,
    output logic [fbc_pkg::HALF_W-1:0]    l_out,
    output logic [fbc_pkg::HALF_W-1:0]    r_out
);

    logic [fbc_pkg::HALF_W-1:0] src;
    logic [fbc_pkg::HALF_W-1:0] mixed;
    logic [fbc_pkg::HALF_W-1:0] subbed;
    logic [fbc_pkg::HALF_W-1:0] f_val;

    // Encryption feeds the right half through F, decryption the left half.
    assign src    = (action == fbc_pkg::ACT_DECRYPT) ? l_in : r_in;
    assign mixed  = src ^ key;
    assign subbed = {fbc_pkg::hi_sub(mixed[fbc_pkg::HALF_W-1 -: fbc_pkg::NIBBLE_W]),
                     fbc_pkg::lo_sub(mixed[fbc_pkg::NIBBLE_W-1:0])};
    assign f_val  = {subbed[fbc_pkg::HALF_W-fbc_pkg::ROTATE_AMOUNT-1:0],
                     subbed[fbc_pkg::HALF_W-1 -: fbc_pkg::ROTATE_AMOUNT]};

    always_comb
    begin
        if (!active)
        begin
            l_out = l_in;
            r_out = r_in;
        end
        else if (action == fbc_pkg::ACT_DECRYPT)
        begin
            l_out = f_val ^ r_in;
            r_out = l_in;
        end
        else
        begin
            l_out = r_in;
            r_out = f_val ^ l_in;
        end
    end

endmodule

// ===== design/fbc_datapath.sv =====
// Input register, unrolled round chain and result register of the Feistel block.
// Depends on fbc_pkg and instantiates fbc_round once per round.
`timescale 1ns / 1ps

module fbc_datapath #(
    parameter int MAX_ROUNDS = fbc_pkg::DEF_MAX_ROUNDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbc_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [fbc_pkg::HALF_W-1:0]    left_in,
    input  logic [fbc_pkg::HALF_W-1:0]    right_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fbc_pkg::HALF_W-1:0]    left_out,
    output logic [fbc_pkg::HALF_W-1:0]    right_out
);

    localparam logic [fbc_pkg::ROUND_COUNT_W-1:0] MAX_CNT =
        fbc_pkg::ROUND_COUNT_W'(MAX_ROUNDS);

    logic                          s1_valid_reg;
    fbc_pkg::action_t              s1_action_reg;
    logic [fbc_pkg::HALF_W-1:0]    s1_left_reg;
    logic [fbc_pkg::HALF_W-1:0]    s1_right_reg;
    logic                          out_valid_reg;
    logic [fbc_pkg::HALF_W-1:0]    left_out_reg;
    logic [fbc_pkg::HALF_W-1:0]    right_out_reg;

    logic                          out_free;
    logic                          s1_free;
    logic [fbc_pkg::ROUND_COUNT_W-1:0] rounds_eff;
    logic [fbc_pkg::HALF_W-1:0]    l_stage [0:MAX_ROUNDS];
    logic [fbc_pkg::HALF_W-1:0]    r_stage [0:MAX_ROUNDS];

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || out_free;
    assign in_stall = !s1_free;

    // Counts above the round limit saturate.
    assign rounds_eff = (cfg.round_count > MAX_CNT) ? MAX_CNT : cfg.round_count;

    assign l_stage[0] = s1_left_reg;
    assign r_stage[0] = s1_right_reg;

    for (genvar i = 0; i < MAX_ROUNDS; i++)
    begin : g_round
        logic [fbc_pkg::ROUND_COUNT_W-1:0] dec_pos;
        logic [fbc_pkg::KEY_IDX_W-1:0]     key_idx;
        logic [fbc_pkg::HALF_W-1:0]        key_byte;
        logic                              active;

        // Decryption walks the keys backward from the last active round.
        assign dec_pos  = rounds_eff - fbc_pkg::ROUND_COUNT_W'(1)
                          - fbc_pkg::ROUND_COUNT_W'(i);
        assign key_idx  = (s1_action_reg == fbc_pkg::ACT_DECRYPT)
                          ? dec_pos[fbc_pkg::KEY_IDX_W-1:0]
                          : fbc_pkg::KEY_IDX_W'(i);
        assign key_byte = cfg.round_keys[key_idx*fbc_pkg::HALF_W +: fbc_pkg::HALF_W];
        assign active   = fbc_pkg::ROUND_COUNT_W'(i) < rounds_eff;

        fbc_round u_round (
            .active (active),
            .action (s1_action_reg),
            .l_in   (l_stage[i]),
            .r_in   (r_stage[i]),
            .key    (key_byte),
            .l_out  (l_stage[i+1]),
            .r_out  (r_stage[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            s1_action_reg <= fbc_pkg::action_t'(action);
            s1_left_reg   <= left_in;
            s1_right_reg  <= right_in;
        end
        if (out_free && s1_valid_reg)
        begin
            left_out_reg  <= l_stage[MAX_ROUNDS];
            right_out_reg <= r_stage[MAX_ROUNDS];
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

// ===== design/fbc_checker.sv =====
// Port-level checker for the Feistel block, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module fbc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] left_out,
    input logic [7:0] right_out,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("result changed while stalled");

    // With the result register empty the input side must never stall.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // A new result appears only for a block that was taken at the input.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a matching input word");

    // The configuration port never back-pressures.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write was held off");

endmodule

bind feistel_block_cipher_16bit fbc_checker u_fbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
